// ----- rtl/bnhq_pkg.sv -----
// Shared types and constants of the blocked n-ary heap queue.
// No dependencies; the interfaces and the top level import this package.
`timescale 1ns / 1ps

package bnhq_pkg;

    localparam int IN_KEY_W  = 32;
    localparam int TAG_W     = 8;
    localparam int STAT_W    = 3;
    localparam int OCC_W     = 9;
    localparam int TAG_COUNT = 256;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_POP    = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_NOP    = 2'd3
    } t_kind;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd2;
    localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd3;
    localparam logic [STAT_W-1:0] ST_MISSING   = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_B,
        S_POP_C,
        S_REM_B,
        S_REM_C,
        S_REM_D,
        S_DIVW,
        S_SU_R,
        S_SU_C,
        S_SD_R,
        S_SD_A,
        S_SD_B,
        S_PUT,
        S_DONE
    } t_state;

endpackage

// ----- rtl/bnhq_if.sv -----
// Handshake channels of the heap queue: request beats in, result beats out.
// Depends on bnhq_pkg for the payload widths.
`timescale 1ns / 1ps

interface bnhq_in_if import bnhq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic [IN_KEY_W-1:0] key;
    logic [TAG_W-1:0]    tag;

    modport source (output valid, kind, key, tag, input ready);
    modport sink   (input valid, kind, key, tag, output ready);
endinterface

interface bnhq_out_if import bnhq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STAT_W-1:0]   status;
    logic [IN_KEY_W-1:0] out_key;
    logic [TAG_W-1:0]    out_tag;
    logic [OCC_W-1:0]    occupancy;

    modport source (output valid, status, out_key, out_tag, occupancy, input ready);
    modport sink   (input valid, status, out_key, out_tag, occupancy, output ready);
endinterface

// ----- rtl/bnhq_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module bnhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/bnhq_divn.sv -----
// Divider by the constant NARY built on a reciprocal multiplication.
// Splits a heap position into block index and offset within the block.
`timescale 1ns / 1ps

module bnhq_divn #(
    parameter int NARY = 8,
    parameter int AW   = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [AW-1:0]            i_dividend,
    output logic                     o_busy,
    output logic                     o_done,
    output logic [AW-1:0]            o_quot,
    output logic [$clog2(NARY)-1:0]  o_rem
);
    localparam int OW = $clog2(NARY);
    localparam int SH = AW + OW;
    localparam int PW = SH + AW;
    // With a shift of AW plus the rounded-up log of NARY the rounded-up
    // reciprocal gives the exact quotient for every AW-bit dividend.
    localparam longint unsigned MUL = ((64'd1 << SH) + 64'(NARY) - 64'd1) / 64'(NARY);

    logic [AW-1:0] r_x;
    logic [AW-1:0] r_q;
    logic [OW-1:0] r_r;
    logic          r_busy;
    logic          r_done;
    logic [PW-1:0] prod;
    logic [AW-1:0] quot;
    logic [AW-1:0] back;

    assign prod = PW'(r_x) * PW'(MUL);
    assign quot = prod[PW-1:SH];
    assign back = AW'(quot * AW'(NARY));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_dividend;
        end
        if (r_busy) begin
            r_q <= quot;
            r_r <= OW'(r_x - back);
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule

// ----- rtl/blocked_nary_heap_queue.sv -----
// Top level of the blocked n-ary min-heap priority queue.
// Depends on bnhq_pkg, bnhq_if, bnhq_ram and bnhq_divn.
`timescale 1ns / 1ps

// The block is a min-priority queue of keyed, tagged entries. Each request
// beat on i_in carries a kind (insert, pop minimum, remove by tag), a key
// and a tag. Every request yields exactly one result beat on o_out with a
// status, the key and tag of a popped or removed entry (zero otherwise) and
// the occupancy after the operation.
// One request is worked on at a time. A rejected request or a no-op goes
// straight to the done state, and the next request can be taken once its
// result has moved to the output register. Insert, and remove of any entry
// but the last, pass the position through the divider before sifting. A
// sift-up level reads the parent, then compares and moves, with another
// divider pass when it crosses into the parent block; a sift-down level reads
// the down child, then the right sibling, then moves. Then the moved entry is
// written, the result is registered and the block returns to idle. The single
// read port of the heap memory sets the cost of each step.
// Reset clears the occupancy and the tag-present bits at once; no clearing
// pass is needed. A finished result sits in the output register while the
// next request is accepted; only the following result waits if the receiver
// keeps ready low.
module blocked_nary_heap_queue
    import bnhq_pkg::*;
#(
    parameter int NARY     = 8,
    parameter int CAPACITY = 256,
    parameter int KEY_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bnhq_in_if.sink     i_in,
    bnhq_out_if.source  o_out
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = AW + 1;
    localparam int DW = AW + 5;
    localparam int OW = $clog2(NARY);
    localparam int EW = KEY_BITS + TAG_W;

    t_state r_state, n_state;

    logic [CW-1:0]        r_cnt, n_cnt;
    logic [TAG_COUNT-1:0] r_present, n_present;
    logic [AW-1:0]        r_pos, n_pos;
    logic [AW-1:0]        r_blk, n_blk;
    logic [OW-1:0]        r_off, n_off;
    logic [KEY_BITS-1:0]  r_k, n_k;
    logic [TAG_W-1:0]     r_t, n_t;
    logic [STAT_W-1:0]    r_status, n_status;
    logic [KEY_BITS-1:0]  r_rkey, n_rkey;
    logic [TAG_W-1:0]     r_rtag, n_rtag;
    logic [EW-1:0]        r_dent, n_dent;
    logic                 r_sdown, n_sdown;

    logic                 r_ov;
    logic [STAT_W-1:0]    r_o_status;
    logic [IN_KEY_W-1:0]  r_o_key;
    logic [TAG_W-1:0]     r_o_tag;
    logic [OCC_W-1:0]     r_o_occ;

    // Memory and divider controls.
    logic                 heap_we;
    logic [AW-1:0]        heap_waddr, heap_raddr;
    logic [EW-1:0]        heap_wdata, heap_rdata;
    logic                 pos_we;
    logic [TAG_W-1:0]     pos_waddr, pos_raddr;
    logic [AW-1:0]        pos_wdata, pos_rdata;
    logic                 div_start, div_busy, div_done;
    logic [AW-1:0]        div_in, div_quot;
    logic [OW-1:0]        div_rem;

    bnhq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (heap_we),
        .i_waddr (heap_waddr),
        .i_wdata (heap_wdata),
        .i_raddr (heap_raddr),
        .o_rdata (heap_rdata)
    );

    bnhq_ram #(.WIDTH(AW), .DEPTH(TAG_COUNT)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (pos_waddr),
        .i_wdata (pos_wdata),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    bnhq_divn #(.NARY(NARY), .AW(AW)) u_divn (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_in),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // Shared decode of the current step.
    logic                accept;
    logic                out_free;
    logic [KEY_BITS-1:0] in_key;
    logic                ins_full;
    logic                tag_here;
    logic [CW-1:0]       cnt_dec;
    logic [KEY_BITS-1:0] rd_key, dent_key;
    logic [TAG_W-1:0]    rd_tag, dent_tag;
    logic                su_cross, su_stop;
    logic [AW-1:0]       up_pos;
    logic [DW-1:0]       down_pos;
    logic [AW:0]         right_pos;
    logic                down_ok, right_ok;
    logic                sd_stop, sd_right;
    logic [EW-1:0]       sd_pick;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_ov || o_out.ready;
    assign in_key   = KEY_BITS'(i_in.key);
    assign ins_full = r_cnt >= CW'(CAPACITY);
    assign tag_here = r_present[i_in.tag];
    assign cnt_dec  = r_cnt - 1'b1;

    assign rd_key   = heap_rdata[KEY_BITS-1:0];
    assign rd_tag   = heap_rdata[EW-1:KEY_BITS];
    assign dent_key = r_dent[KEY_BITS-1:0];
    assign dent_tag = r_dent[EW-1:KEY_BITS];

    // Parent of a slot: the left sibling, or for the first slot of a block
    // the slot whose down block this is.
    assign su_cross = r_off == '0;
    assign up_pos   = su_cross ? r_blk - 1'b1 : r_pos - 1'b1;
    assign su_stop  = rd_key <= r_k;

    assign down_pos  = DW'(NARY) * (DW'(r_pos) + 1'b1);
    assign right_pos = (AW + 1)'(r_pos) + 1'b1;
    assign down_ok   = down_pos < DW'(r_cnt);
    assign right_ok  = (r_off != OW'(NARY - 1)) && (right_pos < (AW + 1)'(r_cnt));

    // Sift-down choice: move only onto a strictly smaller key; the right
    // sibling wins over the down child only when strictly smaller than it.
    assign sd_stop  = (!down_ok || dent_key >= r_k) && (!right_ok || rd_key >= r_k);
    assign sd_right = (!down_ok || dent_key >= r_k) ? 1'b1
                                                    : (right_ok && rd_key < dent_key);
    assign sd_pick  = sd_right ? heap_rdata : r_dent;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_kind'(i_in.kind))
                        KIND_INSERT: n_state = (ins_full || tag_here) ? S_DONE : S_DIVW;
                        KIND_POP:    n_state = (r_cnt == '0) ? S_DONE : S_POP_B;
                        KIND_REMOVE: n_state = tag_here ? S_REM_B : S_DONE;
                        default:     n_state = S_DONE;
                    endcase
                end
            end
            S_POP_B: n_state = (cnt_dec == '0) ? S_DONE : S_POP_C;
            S_POP_C: n_state = S_SD_R;
            S_REM_B: n_state = S_REM_C;
            S_REM_C: n_state = (CW'(r_pos) == cnt_dec) ? S_DONE : S_REM_D;
            S_REM_D: n_state = S_DIVW;
            S_DIVW: begin
                if (div_done) begin
                    n_state = r_sdown ? S_SD_R : S_SU_R;
                end
            end
            S_SU_R: n_state = (r_pos == '0) ? S_PUT : S_SU_C;
            S_SU_C: begin
                if (su_stop) begin
                    n_state = S_PUT;
                end else begin
                    n_state = su_cross ? S_DIVW : S_SU_R;
                end
            end
            S_SD_R: n_state = (!down_ok && !right_ok) ? S_PUT : S_SD_A;
            S_SD_A: n_state = S_SD_B;
            S_SD_B: n_state = sd_stop ? S_PUT : S_SD_R;
            S_PUT:  n_state = S_DONE;
            S_DONE: n_state = out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        n_cnt      = r_cnt;
        n_present  = r_present;
        n_pos      = r_pos;
        n_blk      = r_blk;
        n_off      = r_off;
        n_k        = r_k;
        n_t        = r_t;
        n_status   = r_status;
        n_rkey     = r_rkey;
        n_rtag     = r_rtag;
        n_dent     = r_dent;
        n_sdown    = r_sdown;
        heap_we    = 1'b0;
        heap_waddr = r_pos;
        heap_wdata = {r_t, r_k};
        heap_raddr = '0;
        pos_we     = 1'b0;
        pos_waddr  = r_t;
        pos_wdata  = r_pos;
        pos_raddr  = i_in.tag;
        div_start  = 1'b0;
        div_in     = r_pos;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = ST_OK;
                    n_rkey   = '0;
                    n_rtag   = '0;
                    n_k      = in_key;
                    n_t      = i_in.tag;
                    case (t_kind'(i_in.kind))
                        KIND_INSERT: begin
                            if (ins_full) begin
                                n_status = ST_FULL;
                            end else if (tag_here) begin
                                n_status = ST_DUPLICATE;
                            end else begin
                                n_cnt                = r_cnt + 1'b1;
                                n_present[i_in.tag]  = 1'b1;
                                n_pos                = r_cnt[AW-1:0];
                                n_sdown              = 1'b0;
                                div_start            = 1'b1;
                                div_in               = r_cnt[AW-1:0];
                            end
                        end
                        KIND_POP: begin
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY;
                            end
                        end
                        KIND_REMOVE: begin
                            if (!tag_here) begin
                                n_status = ST_MISSING;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_POP_B: begin
                n_rkey            = rd_key;
                n_rtag            = rd_tag;
                n_present[rd_tag] = 1'b0;
                n_cnt             = cnt_dec;
                heap_raddr        = cnt_dec[AW-1:0];
            end
            S_POP_C: begin
                n_k   = rd_key;
                n_t   = rd_tag;
                n_pos = '0;
                n_blk = '0;
                n_off = '0;
            end
            S_REM_B: begin
                n_pos      = pos_rdata;
                heap_raddr = pos_rdata;
            end
            S_REM_C: begin
                n_rkey         = rd_key;
                n_rtag         = r_t;
                n_present[r_t] = 1'b0;
                n_cnt          = cnt_dec;
                heap_raddr     = cnt_dec[AW-1:0];
            end
            S_REM_D: begin
                n_k       = rd_key;
                n_t       = rd_tag;
                n_sdown   = !(rd_key < r_rkey);
                div_start = 1'b1;
                div_in    = r_pos;
            end
            S_DIVW: begin
                if (div_done) begin
                    n_blk = div_quot;
                    n_off = div_rem;
                end
            end
            S_SU_R: begin
                heap_raddr = up_pos;
            end
            S_SU_C: begin
                heap_raddr = up_pos;
                if (!su_stop) begin
                    heap_we    = 1'b1;
                    heap_wdata = heap_rdata;
                    pos_we     = 1'b1;
                    pos_waddr  = rd_tag;
                    n_pos      = up_pos;
                    if (su_cross) begin
                        n_sdown   = 1'b0;
                        div_start = 1'b1;
                        div_in    = up_pos;
                    end else begin
                        n_off = r_off - 1'b1;
                    end
                end
            end
            S_SD_R: begin
                heap_raddr = down_pos[AW-1:0];
            end
            S_SD_A: begin
                n_dent     = heap_rdata;
                heap_raddr = right_pos[AW-1:0];
            end
            S_SD_B: begin
                if (!sd_stop) begin
                    heap_we    = 1'b1;
                    heap_wdata = sd_pick;
                    pos_we     = 1'b1;
                    pos_waddr  = sd_pick[EW-1:KEY_BITS];
                    if (sd_right) begin
                        n_pos = right_pos[AW-1:0];
                        n_off = r_off + 1'b1;
                    end else begin
                        n_pos = down_pos[AW-1:0];
                        n_blk = r_pos + 1'b1;
                        n_off = '0;
                    end
                end
            end
            S_PUT: begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_present <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_present <= n_present;
            if (r_state == S_DONE && out_free) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_blk    <= n_blk;
        r_off    <= n_off;
        r_k      <= n_k;
        r_t      <= n_t;
        r_status <= n_status;
        r_rkey   <= n_rkey;
        r_rtag   <= n_rtag;
        r_dent   <= n_dent;
        r_sdown  <= n_sdown;
        if (r_state == S_DONE && out_free) begin
            r_o_status <= r_status;
            r_o_key    <= IN_KEY_W'(r_rkey);
            r_o_tag    <= r_rtag;
            r_o_occ    <= OCC_W'(r_cnt);
        end
    end

    assign i_in.ready      = r_state == S_IDLE;
    assign o_out.valid     = r_ov;
    assign o_out.status    = r_o_status;
    assign o_out.out_key   = r_o_key;
    assign o_out.out_tag   = r_o_tag;
    assign o_out.occupancy = r_o_occ;

    // The occupancy never passes the capacity.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CAPACITY))
        else $error("occupancy above capacity");

    // Each request moves the occupancy by at most one entry.
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |=> (r_cnt == $past(r_cnt) || r_cnt + 1'b1 == $past(r_cnt)))
        else $error("occupancy moved by more than one");

    // The divider is never restarted while it is still working.
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    // A finished result reaches the output register unless it is held.
    a_done_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (r_state == S_IDLE && r_ov))
        else $error("result not delivered");
endmodule
